@@ rtl/fre_pkg.sv @@
`default_nettype none

package fre_pkg;

   localparam int RATE_BITS_DEF  = 48;
   localparam int MAX_WINDOW_DEF = 15;
   localparam int PPM_BITS       = 20;
   localparam int DEV_BITS       = 32;

   localparam logic [PPM_BITS-1:0] PPM_ONE     = 20'd1000000;
   localparam logic [4:0]          SHIFT_LIMIT = 5'd16;
   localparam logic [3:0]          WINDOW_MIN  = 4'd3;

   localparam logic [63:0]         NOMINAL_RESET = 64'd206158430208;
   localparam logic [63:0]         MAX_RESET     = 64'd281474976710655;
   localparam logic [PPM_BITS-1:0] HARD_RESET    = 20'd1000;
   localparam logic [PPM_BITS-1:0] LOCAL_RESET   = 20'd500;
   localparam logic [PPM_BITS-1:0] TOL_RESET     = 20'd100;
   localparam logic [3:0]          WINDOW_RESET  = 4'd5;
   localparam logic [4:0]          SHIFT_RESET   = 5'd4;
   localparam logic [3:0]          STABLE_RESET  = 4'd3;

   // register indexes
   localparam logic [2:0] REG_NOMINAL = 3'd0;
   localparam logic [2:0] REG_MAX     = 3'd1;
   localparam logic [2:0] REG_HARD    = 3'd2;
   localparam logic [2:0] REG_LOCAL   = 3'd3;
   localparam logic [2:0] REG_TOL     = 3'd4;
   localparam logic [2:0] REG_WINDOW  = 3'd5;
   localparam logic [2:0] REG_SHIFT   = 3'd6;
   localparam logic [2:0] REG_STABLE  = 3'd7;

   // result status codes
   localparam logic [2:0] STS_UNCONF  = 3'd0;
   localparam logic [2:0] STS_ACCEPT  = 3'd1;
   localparam logic [2:0] STS_BAD_TS  = 3'd2;
   localparam logic [2:0] STS_BAD_SEQ = 3'd3;
   localparam logic [2:0] STS_RANGE   = 3'd4;
   localparam logic [2:0] STS_LOCAL   = 3'd5;

   typedef struct packed {
      logic                done;
      logic                fail;
      logic [DEV_BITS-1:0] dev;
   } ppm_rsp_type;

endpackage

`default_nettype wire

@@ rtl/fre_ram.sv @@
`default_nettype none

module fre_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 15
) (
   input  wire logic                     clock,
   input  wire logic                     wen,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wen) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

@@ rtl/fre_ppm.sv @@
`default_nettype none

// floor(|a-b| * 1000000 / b): serial shift-add multiply, then restoring division
module fre_ppm #(
   parameter int RATE_BITS = fre_pkg::RATE_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [RATE_BITS-1:0] a,
   input  wire logic [RATE_BITS-1:0] b,
   output fre_pkg::ppm_rsp_type      rsp
);

   localparam int PW  = RATE_BITS + fre_pkg::PPM_BITS;
   localparam int NW  = $clog2(PW + 1);
   localparam int DW  = fre_pkg::DEV_BITS;

   typedef enum logic [1:0] {P_IDLE, P_MUL, P_DIV} pstate_type;

   pstate_type                   state_ff;
   logic [PW-1:0]                mcand_ff;
   logic [fre_pkg::PPM_BITS-1:0] mbits_ff;
   logic [PW-1:0]                prod_ff;
   logic [RATE_BITS-1:0]         b_ff;
   logic [RATE_BITS-1:0]         rem_ff;
   logic [DW-1:0]                q_ff;
   logic                         ovf_ff;
   logic [NW-1:0]                cnt_ff;
   logic                         done_ff;
   logic                         fail_ff;
   logic [DW-1:0]                dev_ff;

   logic [RATE_BITS-1:0]         diff;
   logic [RATE_BITS:0]           shifted;
   logic                         ge;
   logic [RATE_BITS:0]           sub;
   logic [DW-1:0]                q_in;
   logic                         ovf_in;

   always_comb begin
      diff    = (a > b) ? (a - b) : (b - a);
      shifted = {rem_ff, prod_ff[PW-1]};
      ge      = shifted >= {1'b0, b_ff};
      sub     = shifted - {1'b0, b_ff};
      q_in    = {q_ff[DW-2:0], ge};
      ovf_in  = ovf_ff | q_ff[DW-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= P_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            P_IDLE: begin
               if (start) begin
                  mcand_ff <= PW'(diff);
                  mbits_ff <= fre_pkg::PPM_ONE;
                  prod_ff  <= '0;
                  b_ff     <= b;
                  cnt_ff   <= '0;
                  state_ff <= P_MUL;
               end
            end
            P_MUL: begin
               if (mbits_ff[0]) begin
                  prod_ff <= prod_ff + mcand_ff;
               end
               mcand_ff <= {mcand_ff[PW-2:0], 1'b0};
               mbits_ff <= mbits_ff >> 1;
               if (cnt_ff == NW'(fre_pkg::PPM_BITS - 1)) begin
                  cnt_ff   <= '0;
                  rem_ff   <= '0;
                  q_ff     <= '0;
                  ovf_ff   <= 1'b0;
                  state_ff <= P_DIV;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            P_DIV: begin
               prod_ff <= {prod_ff[PW-2:0], 1'b0};
               rem_ff  <= ge ? sub[RATE_BITS-1:0] : shifted[RATE_BITS-1:0];
               q_ff    <= q_in;
               ovf_ff  <= ovf_in;
               if (cnt_ff == NW'(PW - 1)) begin
                  done_ff  <= 1'b1;
                  fail_ff  <= ovf_in | (b_ff == '0);
                  dev_ff   <= q_in;
                  state_ff <= P_IDLE;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            default: state_ff <= P_IDLE;
         endcase
      end
   end

   assign rsp.done = done_ff;
   assign rsp.fail = fail_ff;
   assign rsp.dev  = dev_ff;

endmodule

`default_nettype wire

@@ rtl/feedback_rate_estimator.sv @@
// sequencing: each request uses the shared ppm unit for its ppm divisions, checks up to
//   stable_count entries, and runs median scans over the n history entries through the
//   single history ram port
// throughput: one request at a time; ready only between requests
// reset: synchronous, registers return to their defaults, block unconfigured until a write
`default_nettype none

module feedback_rate_estimator #(
   parameter int MAX_WINDOW = fre_pkg::MAX_WINDOW_DEF,
   parameter int RATE_BITS  = fre_pkg::RATE_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // seq_number, arrival_ns, sample_rate
   input  wire logic [((96+RATE_BITS+7)/8)*8-1:0]    req_tdata,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // status, accepted, stable, has_trusted, trusted_rate, deviation_ppm
   output logic      [((38+RATE_BITS+7)/8)*8-1:0]    rsp_tdata,
   input  wire logic                                 csr_wen,
   input  wire logic [2:0]                           csr_index,
   input  wire logic [RATE_BITS-1:0]                 csr_wdata
);

   localparam int AW      = $clog2(MAX_WINDOW);
   localparam int CW      = $clog2(MAX_WINDOW + 1);
   localparam int PB      = fre_pkg::PPM_BITS;
   localparam int DW      = fre_pkg::DEV_BITS;
   localparam int OUT_PAD = ((38 + RATE_BITS + 7) / 8) * 8;

   typedef enum logic [4:0] {
      ST_IDLE, ST_CHECK, ST_NOM_GO, ST_NOM_WAIT, ST_LOC_GO, ST_LOC_WAIT,
      ST_MED_LOAD, ST_MED_CAND, ST_MED_SCAN, ST_HWRITE, ST_TRUST_DIFF,
      ST_TRUST_STEP, ST_RUN, ST_STAB_RD, ST_STAB_GO, ST_STAB_WAIT, ST_FINISH
   } state_type;

   // configuration
   logic [RATE_BITS-1:0] nominal_ff, max_ff;
   logic [PB-1:0]        hard_ff, local_ff, tol_ff;
   logic [3:0]           wl_ff, sc_ff;
   logic [4:0]           shift_ff;
   logic                 cfg_written_ff;
   logic                 cfg_valid, config_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         nominal_ff     <= fre_pkg::NOMINAL_RESET[RATE_BITS-1:0];
         max_ff         <= fre_pkg::MAX_RESET[RATE_BITS-1:0];
         hard_ff        <= fre_pkg::HARD_RESET;
         local_ff       <= fre_pkg::LOCAL_RESET;
         tol_ff         <= fre_pkg::TOL_RESET;
         wl_ff          <= fre_pkg::WINDOW_RESET;
         shift_ff       <= fre_pkg::SHIFT_RESET;
         sc_ff          <= fre_pkg::STABLE_RESET;
         cfg_written_ff <= 1'b0;
      end else if (csr_wen) begin
         cfg_written_ff <= 1'b1;
         unique case (csr_index)
            fre_pkg::REG_NOMINAL: nominal_ff <= csr_wdata;
            fre_pkg::REG_MAX:     max_ff     <= csr_wdata;
            fre_pkg::REG_HARD:    hard_ff    <= PB'(csr_wdata);
            fre_pkg::REG_LOCAL:   local_ff   <= PB'(csr_wdata);
            fre_pkg::REG_TOL:     tol_ff     <= PB'(csr_wdata);
            fre_pkg::REG_WINDOW:  wl_ff      <= csr_wdata[3:0];
            fre_pkg::REG_SHIFT:   shift_ff   <= csr_wdata[4:0];
            fre_pkg::REG_STABLE:  sc_ff      <= csr_wdata[3:0];
            default:              cfg_written_ff <= 1'b1;
         endcase
      end
   end

   always_comb begin
      cfg_valid = (nominal_ff != '0) && (nominal_ff <= max_ff) &&
                  (hard_ff != '0) && (hard_ff < fre_pkg::PPM_ONE) &&
                  (local_ff != '0) && (local_ff <= hard_ff) && (tol_ff <= local_ff) &&
                  (wl_ff >= fre_pkg::WINDOW_MIN) && ({28'd0, wl_ff} <= 32'(MAX_WINDOW)) &&
                  wl_ff[0] && (shift_ff <= fre_pkg::SHIFT_LIMIT) &&
                  (sc_ff != '0) && (sc_ff <= wl_ff);
      config_ok = cfg_written_ff && cfg_valid;
   end

   // sequencer state
   state_type            state_ff, med_ret_ff;
   logic [31:0]          seq_ff, last_seq_ff;
   logic [63:0]          time_ff, last_time_ff;
   logic [RATE_BITS-1:0] rate_ff;
   logic                 seen_ff;
   logic [CW-1:0]        hcount_ff;
   logic [AW-1:0]        base_ff;
   logic [RATE_BITS-1:0] tv_ff;
   logic                 tvalid_ff;
   logic                 stable_ff;
   logic [3:0]           run_ff;
   logic [2:0]           status_ff;
   logic [DW-1:0]        dev_ff, nomdev_ff;
   logic [RATE_BITS-1:0] diff_ff;
   logic                 up_ff;

   // median scan
   logic [CW-1:0]        med_st_ff, med_n_ff, cj_ff, ri_ff, pc_ff, lt_ff, le_ff, si_ff;
   logic                 pv_ff;
   logic [RATE_BITS-1:0] cand_ff, med_ff;

   // result register
   logic                 rsp_valid_ff;
   logic [2:0]           rsp_status_ff;
   logic                 rsp_acc_ff, rsp_stable_ff, rsp_has_ff;
   logic [RATE_BITS-1:0] rsp_rate_ff;
   logic [DW-1:0]        rsp_dev_ff;

   logic [CW-1:0]        wlc, scc;
   logic [CW-1:0]        rd_log;
   logic [AW-1:0]        rd_addr, wr_addr;
   logic                 ram_wen;
   logic [RATE_BITS-1:0] ram_rdata;
   logic                 ppm_start;
   logic [RATE_BITS-1:0] ppm_a, ppm_b;
   fre_pkg::ppm_rsp_type ppm_rsp;

   logic [CW-1:0]        lt_in, le_in, pc_in;
   logic [RATE_BITS-1:0] step;
   logic [3:0]           run_in;

   function automatic logic [AW-1:0] to_phys(input logic [AW-1:0] base,
                                             input logic [CW-1:0] lidx,
                                             input logic [CW-1:0] wlen);
      logic [CW:0] s;
      s = (CW+1)'(base) + (CW+1)'(lidx);
      if (s >= (CW+1)'(wlen)) begin
         s = s - (CW+1)'(wlen);
      end
      return s[AW-1:0];
   endfunction

   always_comb begin
      wlc = CW'(wl_ff);
      scc = CW'(sc_ff);
      unique case (state_ff)
         ST_MED_LOAD, ST_MED_CAND:           rd_log = med_st_ff + cj_ff;
         ST_STAB_RD, ST_STAB_GO, ST_STAB_WAIT: rd_log = med_st_ff + si_ff;
         default:                            rd_log = med_st_ff + ri_ff;
      endcase
      rd_addr = to_phys(base_ff, rd_log, wlc);
      wr_addr = (hcount_ff < wlc) ? to_phys(base_ff, hcount_ff, wlc) : base_ff;
      ram_wen = (state_ff == ST_HWRITE);

      ppm_start = (state_ff == ST_NOM_GO) || (state_ff == ST_LOC_GO) ||
                  (state_ff == ST_STAB_GO);
      unique case (state_ff)
         ST_NOM_GO: begin
            ppm_a = rate_ff;
            ppm_b = nominal_ff;
         end
         ST_LOC_GO: begin
            ppm_a = rate_ff;
            ppm_b = med_ff;
         end
         default: begin
            ppm_a = ram_rdata;
            ppm_b = med_ff;
         end
      endcase

      lt_in = lt_ff + CW'(ram_rdata < cand_ff);
      le_in = le_ff + CW'(ram_rdata <= cand_ff);
      pc_in = pc_ff + 1'b1;

      step   = diff_ff >> shift_ff;
      run_in = (run_ff == 4'hF) ? run_ff : run_ff + 4'd1;
   end

   fre_ram #(.WIDTH(RATE_BITS), .DEPTH(MAX_WINDOW)) u_hist (
      .clock (clock),
      .wen   (ram_wen),
      .waddr (wr_addr),
      .wdata (rate_ff),
      .raddr (rd_addr),
      .rdata (ram_rdata)
   );

   fre_ppm #(.RATE_BITS(RATE_BITS)) u_ppm (
      .clock (clock),
      .reset (reset),
      .start (ppm_start),
      .a     (ppm_a),
      .b     (ppm_b),
      .rsp   (ppm_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seen_ff      <= 1'b0;
         last_seq_ff  <= '0;
         last_time_ff <= '0;
         hcount_ff    <= '0;
         base_ff      <= '0;
         tv_ff        <= '0;
         tvalid_ff    <= 1'b0;
         stable_ff    <= 1'b0;
         run_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  seq_ff   <= req_tdata[31:0];
                  time_ff  <= req_tdata[95:32];
                  rate_ff  <= req_tdata[96+RATE_BITS-1:96];
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               state_ff <= ST_FINISH;
               dev_ff   <= '0;
               if (!config_ok) begin
                  status_ff <= fre_pkg::STS_UNCONF;
               end else if (time_ff[63]) begin
                  status_ff <= fre_pkg::STS_BAD_TS;
                  run_ff    <= '0;
                  stable_ff <= 1'b0;
               end else if (seen_ff && (seq_ff <= last_seq_ff)) begin
                  status_ff <= fre_pkg::STS_BAD_SEQ;
                  run_ff    <= '0;
                  stable_ff <= 1'b0;
               end else if (seen_ff && ($signed(time_ff) <= $signed(last_time_ff))) begin
                  status_ff <= fre_pkg::STS_BAD_TS;
                  run_ff    <= '0;
                  stable_ff <= 1'b0;
               end else begin
                  seen_ff      <= 1'b1;
                  last_seq_ff  <= seq_ff;
                  last_time_ff <= time_ff;
                  if ((rate_ff == '0) || (rate_ff > max_ff)) begin
                     status_ff <= fre_pkg::STS_RANGE;
                     dev_ff    <= DW'(fre_pkg::PPM_ONE);
                     run_ff    <= '0;
                     stable_ff <= 1'b0;
                  end else begin
                     state_ff <= ST_NOM_GO;
                  end
               end
            end
            ST_NOM_GO: state_ff <= ST_NOM_WAIT;
            ST_NOM_WAIT: begin
               if (ppm_rsp.done) begin
                  if (ppm_rsp.fail || (ppm_rsp.dev > DW'(hard_ff))) begin
                     status_ff <= fre_pkg::STS_RANGE;
                     dev_ff    <= ppm_rsp.fail ? '0 : ppm_rsp.dev;
                     run_ff    <= '0;
                     stable_ff <= 1'b0;
                     state_ff  <= ST_FINISH;
                  end else begin
                     nomdev_ff <= ppm_rsp.dev;
                     if (hcount_ff >= CW'(fre_pkg::WINDOW_MIN)) begin
                        med_st_ff  <= '0;
                        med_n_ff   <= hcount_ff;
                        cj_ff      <= '0;
                        med_ret_ff <= ST_LOC_GO;
                        state_ff   <= ST_MED_LOAD;
                     end else begin
                        state_ff <= ST_HWRITE;
                     end
                  end
               end
            end
            ST_LOC_GO: state_ff <= ST_LOC_WAIT;
            ST_LOC_WAIT: begin
               if (ppm_rsp.done) begin
                  if (ppm_rsp.fail || (ppm_rsp.dev > DW'(local_ff))) begin
                     status_ff <= fre_pkg::STS_LOCAL;
                     dev_ff    <= ppm_rsp.fail ? '0 : ppm_rsp.dev;
                     run_ff    <= '0;
                     stable_ff <= 1'b0;
                     state_ff  <= ST_FINISH;
                  end else begin
                     state_ff <= ST_HWRITE;
                  end
               end
            end
            ST_MED_LOAD: state_ff <= ST_MED_CAND;
            ST_MED_CAND: begin
               cand_ff  <= ram_rdata;
               ri_ff    <= '0;
               pv_ff    <= 1'b0;
               lt_ff    <= '0;
               le_ff    <= '0;
               pc_ff    <= '0;
               state_ff <= ST_MED_SCAN;
            end
            ST_MED_SCAN: begin
               // one read issued per cycle, compared against the candidate in the following cycle
               if (ri_ff < med_n_ff) begin
                  ri_ff <= ri_ff + 1'b1;
                  pv_ff <= 1'b1;
               end else begin
                  pv_ff <= 1'b0;
               end
               if (pv_ff) begin
                  lt_ff <= lt_in;
                  le_ff <= le_in;
                  pc_ff <= pc_in;
                  if (pc_in == med_n_ff) begin
                     if ((lt_in <= (med_n_ff >> 1)) && (le_in > (med_n_ff >> 1))) begin
                        med_ff   <= cand_ff;
                        state_ff <= med_ret_ff;
                     end else begin
                        cj_ff    <= cj_ff + 1'b1;
                        state_ff <= ST_MED_LOAD;
                     end
                  end
               end
            end
            ST_HWRITE: begin
               if (hcount_ff < wlc) begin
                  med_n_ff  <= hcount_ff + 1'b1;
                  hcount_ff <= hcount_ff + 1'b1;
               end else begin
                  med_n_ff <= hcount_ff;
                  base_ff  <= ((CW'(base_ff) + 1'b1) == wlc) ? '0 : base_ff + 1'b1;
               end
               med_st_ff  <= '0;
               cj_ff      <= '0;
               med_ret_ff <= ST_TRUST_DIFF;
               state_ff   <= ST_MED_LOAD;
            end
            ST_TRUST_DIFF: begin
               if (!tvalid_ff || (shift_ff == '0)) begin
                  tv_ff    <= med_ff;
                  state_ff <= ST_RUN;
               end else begin
                  up_ff    <= med_ff > tv_ff;
                  diff_ff  <= (med_ff > tv_ff) ? (med_ff - tv_ff) : (tv_ff - med_ff);
                  state_ff <= ST_TRUST_STEP;
               end
            end
            ST_TRUST_STEP: begin
               if (diff_ff != '0) begin
                  if (up_ff) begin
                     tv_ff <= tv_ff + ((step == '0) ? RATE_BITS'(1) : step);
                  end else begin
                     tv_ff <= tv_ff - ((step == '0) ? RATE_BITS'(1) : step);
                  end
               end
               state_ff <= ST_RUN;
            end
            ST_RUN: begin
               tvalid_ff <= 1'b1;
               run_ff    <= run_in;
               status_ff <= fre_pkg::STS_ACCEPT;
               dev_ff    <= nomdev_ff;
               if ((run_in >= sc_ff) && (hcount_ff >= scc)) begin
                  med_st_ff  <= hcount_ff - scc;
                  med_n_ff   <= scc;
                  cj_ff      <= '0;
                  si_ff      <= '0;
                  med_ret_ff <= ST_STAB_RD;
                  state_ff   <= ST_MED_LOAD;
               end else begin
                  stable_ff <= 1'b0;
                  state_ff  <= ST_FINISH;
               end
            end
            ST_STAB_RD: state_ff <= ST_STAB_GO;
            ST_STAB_GO: state_ff <= ST_STAB_WAIT;
            ST_STAB_WAIT: begin
               if (ppm_rsp.done) begin
                  if (ppm_rsp.fail || (ppm_rsp.dev > DW'(tol_ff))) begin
                     stable_ff <= 1'b0;
                     state_ff  <= ST_FINISH;
                  end else if ((si_ff + 1'b1) == scc) begin
                     stable_ff <= 1'b1;
                     state_ff  <= ST_FINISH;
                  end else begin
                     si_ff    <= si_ff + 1'b1;
                     state_ff <= ST_STAB_RD;
                  end
               end
            end
            ST_FINISH: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= status_ff;
                  rsp_acc_ff    <= status_ff == fre_pkg::STS_ACCEPT;
                  rsp_stable_ff <= (status_ff == fre_pkg::STS_ACCEPT) && stable_ff;
                  if (status_ff == fre_pkg::STS_UNCONF) begin
                     rsp_has_ff  <= 1'b0;
                     rsp_rate_ff <= '0;
                     rsp_dev_ff  <= '0;
                  end else begin
                     rsp_has_ff  <= tvalid_ff;
                     rsp_rate_ff <= tvalid_ff ? tv_ff : '0;
                     rsp_dev_ff  <= dev_ff;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
         // a register write clears the estimator history
         if (csr_wen) begin
            seen_ff      <= 1'b0;
            last_seq_ff  <= '0;
            last_time_ff <= '0;
            hcount_ff    <= '0;
            base_ff      <= '0;
            tv_ff        <= '0;
            tvalid_ff    <= 1'b0;
            stable_ff    <= 1'b0;
            run_ff       <= '0;
         end
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = OUT_PAD'({rsp_dev_ff, rsp_rate_ff, rsp_has_ff, rsp_stable_ff,
                                 rsp_acc_ff, rsp_status_ff});

`ifndef SYNTH
   a_busy_after_request: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while previous one in progress");

   a_no_trusted_rate: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_has_ff) |-> (rsp_rate_ff == '0))
      else $error("trusted rate reported without trusted value");

   a_accept_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_acc_ff == (rsp_status_ff == fre_pkg::STS_ACCEPT)))
      else $error("accepted flag disagrees with status");

   a_history_fill: assert property (@(posedge clock) disable iff (reset)
      config_ok |-> (hcount_ff <= wlc))
      else $error("history count beyond window length");
`endif

endmodule

`default_nettype wire

@@ bench/tb_feedback_rate_estimator.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tb_feedback_rate_estimator;

   localparam int RB = 48;
   localparam logic [47:0] RATE_ALL = 48'hFFFF_FFFF_FFFF;
   localparam longint LIMIT_CYCLES = 40_000_000;

   typedef struct packed {
      logic [RB-1:0] rate;
      logic [63:0]   ts;
      logic [31:0]   seq;
   } sample_type;

   typedef struct {
      logic [2:0]    status;
      logic          accepted;
      logic          stable;
      logic          has_trusted;
      logic [RB-1:0] trusted;
      logic [31:0]   dev;
   } estimate_type;

   logic           clock = 1'b0;
   logic           reset = 1'b1;
   logic           req_tvalid = 1'b0;
   logic           req_tready;
   logic [143:0]   req_tdata = '0;
   logic           rsp_tvalid;
   logic           rsp_tready = 1'b0;
   logic [87:0]    rsp_tdata;
   logic           csr_wen = 1'b0;
   logic [2:0]     csr_index = '0;
   logic [RB-1:0]  csr_wdata = '0;

   feedback_rate_estimator u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wen(csr_wen), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   // ---------------- estimator state of the predictor ----------------
   logic [63:0] nominal_q, max_q;
   logic [19:0] hard_q, local_q, tol_q;
   logic [3:0]  win_q, stc_q;
   logic [4:0]  shift_q;
   logic [63:0] hist [0:14];
   int          hist_n;
   logic [63:0] trust_q, last_ts;
   logic [31:0] last_seq, run_n;
   bit          seen_q, trust_ok, stable_q, cfg_ok;

   sample_type   pending_samples [$];
   estimate_type expected_estimates [$];
   int        errors = 0;
   bit        no_idle = 1'b0;
   logic      req_fired = 1'b0;

   // generator cursors
   logic [31:0] gen_seq;
   logic [63:0] gen_ts;

   function automatic bit ppm_of(input logic [63:0] a, input logic [63:0] b,
                                 output logic [31:0] r);
      logic [63:0]  d;
      logic [127:0] p;
      r = '0;
      if (b == 0) return 1'b0;
      d = a > b ? a - b : b - a;
      p = (128'(d) * 128'd1000000) / 128'(b);
      if (p > 128'hFFFF_FFFF) return 1'b0;
      r = p[31:0];
      return 1'b1;
   endfunction

   function automatic logic [63:0] hist_median(input int first, input int cnt);
      logic [63:0] buf_v [0:14];
      logic [63:0] v;
      int j;
      for (int i = 0; i < cnt; i++) begin
         v = hist[first + i];
         j = i;
         while (j > 0 && buf_v[j-1] > v) begin
            buf_v[j] = buf_v[j-1];
            j--;
         end
         buf_v[j] = v;
      end
      return buf_v[cnt / 2];
   endfunction

   function automatic void clear_estimator();
      for (int i = 0; i < 15; i++) hist[i] = '0;
      hist_n = 0; trust_q = '0; last_seq = '0; last_ts = '0;
      seen_q = 0; trust_ok = 0; stable_q = 0; run_n = '0;
   endfunction

   function automatic void apply_register(input logic [2:0] idx, input logic [RB-1:0] val);
      case (idx)
         fre_pkg::REG_NOMINAL: nominal_q = 64'(val);
         fre_pkg::REG_MAX:     max_q = 64'(val);
         fre_pkg::REG_HARD:    hard_q = val[19:0];
         fre_pkg::REG_LOCAL:   local_q = val[19:0];
         fre_pkg::REG_TOL:     tol_q = val[19:0];
         fre_pkg::REG_WINDOW:  win_q = val[3:0];
         fre_pkg::REG_SHIFT:   shift_q = val[4:0];
         fre_pkg::REG_STABLE:  stc_q = val[3:0];
      endcase
      clear_estimator();
      cfg_ok = nominal_q != 0 && nominal_q <= max_q && hard_q != 0 && hard_q < 1000000 &&
               local_q != 0 && local_q <= hard_q && tol_q <= local_q &&
               win_q >= 3 && win_q <= 15 && win_q[0] && shift_q <= 16 &&
               stc_q != 0 && stc_q <= win_q;
   endfunction

   function automatic estimate_type finish(input logic [2:0] st, input logic [31:0] dv);
      estimate_type e;
      if (st != fre_pkg::STS_ACCEPT) begin
         run_n = '0;
         stable_q = 0;
      end
      e.status = st;
      e.accepted = st == fre_pkg::STS_ACCEPT;
      e.stable = st == fre_pkg::STS_ACCEPT && stable_q;
      e.has_trusted = trust_ok;
      e.trusted = trust_ok ? trust_q[RB-1:0] : '0;
      e.dev = dv;
      return e;
   endfunction

   function automatic bit window_settled();
      int first;
      logic [63:0] med;
      logic [31:0] dv;
      if (hist_n < stc_q) return 1'b0;
      first = hist_n - stc_q;
      med = hist_median(first, stc_q);
      for (int i = first; i < hist_n; i++)
         if (!ppm_of(hist[i], med, dv) || dv > tol_q) return 1'b0;
      return 1'b1;
   endfunction

   function automatic estimate_type estimate_sample(input sample_type s);
      estimate_type e;
      logic [63:0] rate, med, diff, stp;
      logic [31:0] nom_dev, loc_dev;
      rate = 64'(s.rate);
      if (!cfg_ok) begin
         e = '{default: '0};
         return e;
      end
      if (s.ts[63]) return finish(fre_pkg::STS_BAD_TS, '0);
      if (seen_q && s.seq <= last_seq) return finish(fre_pkg::STS_BAD_SEQ, '0);
      if (seen_q && s.ts <= last_ts) return finish(fre_pkg::STS_BAD_TS, '0);
      seen_q = 1; last_seq = s.seq; last_ts = s.ts;
      if (rate == 0 || rate > max_q) return finish(fre_pkg::STS_RANGE, 32'd1000000);
      if (!ppm_of(rate, nominal_q, nom_dev)) return finish(fre_pkg::STS_RANGE, '0);
      if (nom_dev > hard_q) return finish(fre_pkg::STS_RANGE, nom_dev);
      if (hist_n >= 3) begin
         med = hist_median(0, hist_n);
         if (!ppm_of(rate, med, loc_dev)) return finish(fre_pkg::STS_LOCAL, '0);
         if (loc_dev > local_q) return finish(fre_pkg::STS_LOCAL, loc_dev);
      end
      if (hist_n < win_q) begin
         hist[hist_n] = rate;
         hist_n++;
      end else begin
         for (int i = 1; i < hist_n; i++) hist[i-1] = hist[i];
         hist[hist_n-1] = rate;
      end
      med = hist_median(0, hist_n);
      if (!trust_ok || shift_q == 0) trust_q = med;
      else if (med != trust_q) begin
         diff = med > trust_q ? med - trust_q : trust_q - med;
         stp = diff >> shift_q;
         if (stp == 0) stp = 1;
         trust_q = med > trust_q ? trust_q + stp : trust_q - stp;
      end
      trust_ok = 1;
      if (run_n != 32'hFFFF_FFFF) run_n++;
      stable_q = run_n >= stc_q && window_settled();
      return finish(fre_pkg::STS_ACCEPT, nom_dev);
   endfunction

   // ---------------- driver, receiver and checker ----------------
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_fired) begin
            if (pending_samples.size() != 0 && (no_idle || $urandom_range(99) >= 18)) begin
               req_tdata <= pending_samples.pop_front();
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= no_idle || $urandom_range(99) >= 18;
      end
   end

   always @(posedge clock) begin
      estimate_type e, got;
      sample_type s;
      req_fired <= req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready) begin
         s = req_tdata;
         expected_estimates.push_back(estimate_sample(s));
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status = rsp_tdata[2:0];
         got.accepted = rsp_tdata[3];
         got.stable = rsp_tdata[4];
         got.has_trusted = rsp_tdata[5];
         got.trusted = rsp_tdata[53:6];
         got.dev = rsp_tdata[85:54];
         if (expected_estimates.size() == 0) begin
            $error("estimate with no request outstanding");
            errors++;
         end else begin
            e = expected_estimates.pop_front();
            if (got.status !== e.status) begin
               $error("status: expected %0d, got %0d", e.status, got.status); errors++;
            end
            if (got.accepted !== e.accepted) begin
               $error("accepted: expected %0d, got %0d", e.accepted, got.accepted); errors++;
            end
            if (got.stable !== e.stable) begin
               $error("stable: expected %0d, got %0d", e.stable, got.stable); errors++;
            end
            if (got.has_trusted !== e.has_trusted) begin
               $error("has_trusted: expected %0d, got %0d", e.has_trusted, got.has_trusted);
               errors++;
            end
            if (got.trusted !== e.trusted) begin
               $error("trusted_rate: expected %0h, got %0h", e.trusted, got.trusted); errors++;
            end
            if (got.dev !== e.dev) begin
               $error("deviation_ppm: expected %0d, got %0d", e.dev, got.dev); errors++;
            end
         end
      end
   end

   longint cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // ---------------- stimulus ----------------
   task automatic wait_quiet();
      do @(posedge clock);
      while (pending_samples.size() != 0 || req_tvalid || expected_estimates.size() != 0);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [RB-1:0] val);
      @(negedge clock);
      csr_wen <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(negedge clock);
      csr_wen <= 1'b0;
      apply_register(idx, val);
   endtask

   task automatic configure(input logic [RB-1:0] nom, input logic [RB-1:0] mx,
                            input logic [19:0] hd, input logic [19:0] lc,
                            input logic [19:0] tl, input logic [3:0] wn,
                            input logic [4:0] sh, input logic [3:0] sc);
      wait_quiet();
      csr_write(fre_pkg::REG_NOMINAL, nom);
      csr_write(fre_pkg::REG_MAX, mx);
      csr_write(fre_pkg::REG_HARD, {28'hABCDEF1, hd});  // upper bits must be dropped
      csr_write(fre_pkg::REG_LOCAL, 48'(lc));
      csr_write(fre_pkg::REG_TOL, 48'(tl));
      csr_write(fre_pkg::REG_WINDOW, {44'h5A5, wn});
      csr_write(fre_pkg::REG_SHIFT, 48'(sh));
      csr_write(fre_pkg::REG_STABLE, 48'(sc));
      gen_seq = $urandom_range(0, 1000);
      gen_ts = {2'b00, 30'($urandom), 32'($urandom)};
   endtask

   function automatic logic [RB-1:0] rate_near(input int ppm);
      logic [127:0] d;
      d = (128'(nominal_q) * 128'(ppm)) / 128'd1000000;
      if ($urandom_range(1)) return RB'(nominal_q + d[63:0]);
      return nominal_q > d[63:0] ? RB'(nominal_q - d[63:0]) : RB'(0);
   endfunction

   task automatic push_sample(input logic [31:0] sq, input logic [63:0] t,
                              input logic [RB-1:0] r);
      sample_type s;
      s.seq = sq; s.ts = t; s.rate = r;
      pending_samples.push_back(s);
   endtask

   task automatic push_good(input int ppm);
      gen_seq += $urandom_range(1, 3);
      gen_ts += $urandom_range(1, 1_000_000);
      push_sample(gen_seq, gen_ts, rate_near(ppm));
   endtask

   task automatic random_run(input int n);
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if (r < 70) push_good($urandom_range(0, local_q / 3));
         else if (r < 78) push_good($urandom_range(0, hard_q + hard_q / 4));
         else begin
            case ($urandom_range(7))
               0: push_sample(gen_seq, gen_ts + 1, rate_near(0));          // stale sequence
               1: begin gen_seq++; push_sample(gen_seq, gen_ts, rate_near(0)); end
               2: begin
                  gen_seq++;
                  push_sample(gen_seq, {1'b1, 31'($urandom), 32'($urandom)}, rate_near(0));
               end
               3: begin gen_seq++; gen_ts++; push_sample(gen_seq, gen_ts, '0); end
               4: begin
                  gen_seq++; gen_ts++;
                  push_sample(gen_seq, gen_ts, {16'($urandom), 32'($urandom)});
               end
               5: begin gen_seq++; gen_ts++; push_sample(gen_seq, gen_ts, RATE_ALL); end
               6: begin
                  // big jumps so the upper bits of sequence and time toggle
                  gen_seq += $urandom;
                  gen_ts += {1'b0, 29'($urandom), 34'($urandom)};
                  push_sample(gen_seq, gen_ts, rate_near(0));
               end
               default: push_sample(gen_seq - 1, gen_ts - 1, rate_near(0));
            endcase
         end
      end
   endtask

   initial begin
      nominal_q = fre_pkg::NOMINAL_RESET; max_q = fre_pkg::MAX_RESET;
      hard_q = fre_pkg::HARD_RESET; local_q = fre_pkg::LOCAL_RESET;
      tol_q = fre_pkg::TOL_RESET; win_q = fre_pkg::WINDOW_RESET;
      shift_q = fre_pkg::SHIFT_RESET; stc_q = fre_pkg::STABLE_RESET; cfg_ok = 0;
      clear_estimator();
      gen_seq = 0; gen_ts = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // unconfigured after reset
      push_sample(32'd5, 64'd100, RB'(fre_pkg::NOMINAL_RESET));
      push_sample(32'hFFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, RATE_ALL);

      // directed: defaults, each reject path and the trusted/stable build-up
      configure(RB'(fre_pkg::NOMINAL_RESET), RB'(fre_pkg::MAX_RESET), fre_pkg::HARD_RESET,
                fre_pkg::LOCAL_RESET, fre_pkg::TOL_RESET, fre_pkg::WINDOW_RESET,
                fre_pkg::SHIFT_RESET, fre_pkg::STABLE_RESET);
      push_sample(32'd0, 64'd0, rate_near(0));
      push_sample(32'd1, 64'd10, rate_near(50));
      push_sample(32'd1, 64'd20, rate_near(0));                // repeated sequence
      push_sample(32'd2, 64'd10, rate_near(0));                // time not rising
      push_sample(32'd3, 64'h8000_0000_0000_0000, rate_near(0)); // negative time
      push_sample(32'd4, 64'd30, '0);
      push_sample(32'd5, 64'd40, RATE_ALL);
      push_sample(32'd6, 64'd50, rate_near(1001));
      push_sample(32'd7, 64'd60, rate_near(1000));
      push_sample(32'd8, 64'd70, rate_near(10));
      push_sample(32'd9, 64'd80, rate_near(20));
      push_sample(32'd10, 64'd90, rate_near(0));
      push_sample(32'd11, 64'd100, RB'(nominal_q + nominal_q / 1250)); // local outlier
      push_sample(32'd12, 64'd110, rate_near(5));
      push_sample(32'd13, 64'd120, rate_near(5));
      push_sample(32'd14, 64'd130, rate_near(5));
      push_sample(32'hFFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, rate_near(5));
      push_sample(32'd16, 64'd140, rate_near(5));

      no_idle = 1'b1;
      random_run(150);
      wait_quiet();
      no_idle = 1'b0;
      random_run(100);

      // tiny nominal, widest bands, window at its largest, direct follow
      configure(48'd1, RATE_ALL, 20'd999999, 20'd999999, 20'd999999, 4'd15, 5'd0, 4'd15);
      random_run(100);

      // largest nominal, narrowest bands, slowest slew
      configure(RATE_ALL, RATE_ALL, 20'd1, 20'd1, 20'd0, 4'd3, 5'd16, 4'd1);
      random_run(100);

      // max rate just above nominal
      configure(RB'(fre_pkg::NOMINAL_RESET), RB'(fre_pkg::NOMINAL_RESET + 48'd100000),
                20'd2000, 20'd300, 20'd50, 4'd7, 5'd1, 4'd5);
      random_run(150);

      // invalid set: even window leaves the block unconfigured
      configure(RB'(fre_pkg::NOMINAL_RESET), RATE_ALL, 20'd1000, 20'd500, 20'd100, 4'd4,
                5'd4, 4'd3);
      random_run(25);

      configure({16'($urandom_range(1, 65535)), 32'($urandom)}, RATE_ALL, 20'd1000,
                20'd800, 20'd200, 4'd13, 5'd2, 4'd13);
      random_run(255);

      wait_quiet();
      repeat (2000) @(posedge clock);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/fre_pkg.sv
rtl/fre_ram.sv
rtl/fre_ppm.sv
rtl/feedback_rate_estimator.sv
bench/tb_feedback_rate_estimator.sv
